FILE: hdl/fpba_pkg.sv
// Package for the fit policy block allocator: sizes, codes and the types
// carried along the cell chain. No dependencies.
package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LIM_W      = IDX_W + 1;

  localparam int OP_W       = 1;
  localparam int SLOT_W     = 4;
  localparam int AMT_W      = 16;
  localparam int CHOSEN_W   = 4;
  localparam int SPACE_W    = 16;
  localparam int MODE_W     = 2;
  localparam int BIU_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE      = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic [SIZE_BITS-1:0] amt;
    logic [MODE_W-1:0]    mode;
    logic [LIM_W-1:0]     limit;
    logic                 last;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] pick_val;
  } tok_t;

  // entry write bus, shared by loads and charges
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } wr_t;

endpackage

FILE: hdl/fpba_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on fpba_pkg.
interface fpba_in_if;
  import fpba_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SLOT_W-1:0]   block_slot;
  logic [AMT_W-1:0]    amount;
  logic                final_request;

  modport source (output valid, operation, block_slot, amount, final_request, input ready);
  modport sink   (input valid, operation, block_slot, amount, final_request, output ready);
endinterface

interface fpba_out_if;
  import fpba_pkg::*;
  logic                valid;
  logic                ready;
  logic                granted;
  logic [CHOSEN_W-1:0] chosen_block;
  logic [SPACE_W-1:0]  space_left;
  logic                batch_done;

  modport source (output valid, granted, chosen_block, space_left, batch_done, input ready);
  modport sink   (input valid, granted, chosen_block, space_left, batch_done, output ready);
endinterface

FILE: hdl/fpba_cell.sv
// One cell of the search chain: holds one free-space entry, updates the
// passing search token and registers it for the next cell. Depends on fpba_pkg.
module fpba_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [fpba_pkg::IDX_W-1:0] cell_idx_i,
  input  fpba_pkg::wr_t            wr_i,
  input  logic                     tok_vld_i,
  input  fpba_pkg::tok_t           tok_i,
  output logic                     tok_vld_o,
  output fpba_pkg::tok_t           tok_o
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] entry_q;
  logic                 tok_vld_q;
  tok_t                 tok_q, tok_d;
  logic                 fits, take;

  always_comb begin
    tok_d = tok_i;
    fits  = ({1'b0, cell_idx_i} < tok_i.limit) && (entry_q >= tok_i.amt);
    take  = 1'b0;
    if (fits) begin
      if (!tok_i.found) begin
        take = 1'b1;
      end else if (tok_i.mode == FIT_BEST) begin
        take = entry_q < tok_i.pick_val;
      end else if (tok_i.mode == FIT_WORST) begin
        take = entry_q > tok_i.pick_val;
      end
    end
    if (take) begin
      tok_d.found    = 1'b1;
      tok_d.pick     = cell_idx_i;
      tok_d.pick_val = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      entry_q <= wr_i.data;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

FILE: hdl/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: control, configuration,
// result register and the chain of fpba_cell. Depends on fpba_pkg, fpba_if.
//
// A load word writes one table entry. A request word travels down a chain of
// NUM_BLOCKS cells, one cell per cycle, each cell holding one entry and
// comparing it against the best fit so far; the chosen entry is then charged
// and the result registered. Input is taken again once the result is
// registered, even while it waits to be read. Entries hold nothing useful
// until loaded.
module fit_policy_block_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fpba_in_if.sink                         req_i,
  fpba_out_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fpba_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [MODE_W-1:0]    fit_mode_q;
  logic [BIU_W-1:0]     biu_q;
  tok_t                 fin_q, fin_d;
  logic                 out_vld_q;
  logic                 out_granted_q, out_last_q;
  logic [CHOSEN_W-1:0]  out_chosen_q;
  logic [SPACE_W-1:0]   out_space_q;

  logic                 accept, out_load;
  logic [LIM_W-1:0]     limit;
  logic [SIZE_BITS-1:0] left;
  wr_t                  wr;
  logic                 tok_vld [NUM_BLOCKS+1];
  tok_t                 tok     [NUM_BLOCKS+1];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    if (32'(biu_q) > 32'(NUM_BLOCKS)) begin
      limit = LIM_W'(NUM_BLOCKS);
    end else begin
      limit = LIM_W'(biu_q);
    end
  end

  assign tok_vld[0]      = accept && (req_i.operation == OP_REQUEST);
  assign tok[0].amt      = SIZE_BITS'(req_i.amount);
  assign tok[0].mode     = fit_mode_q;
  assign tok[0].limit    = limit;
  assign tok[0].last     = req_i.final_request;
  assign tok[0].found    = 1'b0;
  assign tok[0].pick     = '0;
  assign tok[0].pick_val = '0;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    fpba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(k)),
      .wr_i       (wr),
      .tok_vld_i  (tok_vld[k]),
      .tok_i      (tok[k]),
      .tok_vld_o  (tok_vld[k+1]),
      .tok_o      (tok[k+1])
    );
  end

  assign left = fin_q.pick_val - fin_q.amt;

  always_comb begin
    state_d  = state_q;
    fin_d    = fin_q;
    out_load = 1'b0;
    wr.en    = 1'b0;
    wr.idx   = IDX_W'(req_i.block_slot);
    wr.data  = SIZE_BITS'(req_i.amount);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_REQUEST) begin
            state_d = ST_SCAN;
          end else begin
            wr.en = 32'(req_i.block_slot) < 32'(NUM_BLOCKS);
          end
        end
      end
      ST_SCAN: begin
        if (tok_vld[NUM_BLOCKS]) begin
          fin_d   = tok[NUM_BLOCKS];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          wr.en    = fin_q.found;
          wr.idx   = fin_q.pick;
          wr.data  = left;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fit_mode_q <= FIT_FIRST;
      biu_q      <= BIU_RESET;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FIT_MODE:      fit_mode_q <= cfg_data_i[MODE_W-1:0];
          REG_BLOCKS_IN_USE: biu_q      <= cfg_data_i[BIU_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    if (out_load) begin
      out_granted_q <= fin_q.found;
      out_last_q    <= fin_q.last;
      out_chosen_q  <= fin_q.found ? CHOSEN_W'(fin_q.pick) : '0;
      out_space_q   <= fin_q.found ? SPACE_W'(left) : '0;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.granted      = out_granted_q;
  assign rsp_o.chosen_block = out_chosen_q;
  assign rsp_o.space_left   = out_space_q;
  assign rsp_o.batch_done   = out_last_q;

endmodule
